@@ sv/ehc_pkg.sv @@
package ehc_pkg;

  // ethertypes
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;

  // ipv4 protocol numbers
  localparam logic [7:0] PROTO_IPV6 = 8'h29;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // dhcp ports
  localparam logic [15:0] DHCP_CLIENT_PORT = 16'd68;
  localparam logic [15:0] DHCP_SERVER_PORT = 16'd67;

  localparam logic [3:0] IHL_MASK = 4'hF;
  localparam logic [3:0] IHL_MIN  = 4'd5;

  // frame offsets
  localparam logic [6:0] OFS_MAX       = 7'd127;
  localparam logic [6:0] OFS_SRC_MAC   = 7'd6;
  localparam logic [6:0] OFS_TYPE      = 7'd12;
  localparam logic [6:0] OFS_IHL       = 7'd14;
  localparam logic [6:0] OFS_PROTO     = 7'd23;
  localparam logic [6:0] OFS_IP_SRC    = 7'd26;
  localparam logic [6:0] OFS_IP_DST    = 7'd30;
  localparam logic [6:0] OFS_IP_END    = 7'd34;
  localparam logic [6:0] OFS_ARP_SMAC  = 7'd22;
  localparam logic [6:0] OFS_ARP_SIP   = 7'd28;
  localparam logic [6:0] OFS_ARP_TMAC  = 7'd32;
  localparam logic [6:0] OFS_ARP_TIP   = 7'd38;
  localparam logic [6:0] OFS_ARP_END   = 7'd42;
  localparam logic [6:0] OFS_PORT_BASE = 7'd14;
  localparam logic [6:0] OFS_PORT_NEED = 7'd17;

  // packet kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_ARP   = 3'd1;
  localparam logic [2:0] KIND_TCP   = 3'd2;
  localparam logic [2:0] KIND_DHCP  = 3'd3;
  localparam logic [2:0] KIND_UDP   = 3'd4;

  // reject reasons
  localparam logic [2:0] RSN_OK        = 3'd0;
  localparam logic [2:0] RSN_ETHERTYPE = 3'd1;
  localparam logic [2:0] RSN_IPV6      = 3'd2;
  localparam logic [2:0] RSN_PROTO     = 3'd3;
  localparam logic [2:0] RSN_NOT_LOCAL = 3'd4;
  localparam logic [2:0] RSN_TRUNC     = 3'd5;

endpackage

@@ sv/ethernet_header_classifier.sv @@
// ethernet header classifier: takes a frame one byte per beat on data_byte, starting at the
// destination mac, with last_byte marking the final beat. it captures the macs, the
// ethertype and, for ipv4, ihl, protocol, addresses and the tcp/udp ports at 14 + 4*ihl;
// for arp it captures sender and target hardware and protocol addresses. the final beat of
// each frame produces exactly one result beat (kind, reject reason, addresses, ports); other
// beats produce none. a new byte is taken every cycle while the input register is not stalled;
// a last byte passes from the input register into the result register, where its result
// beat waits until it is taken. the result register holds one result, so a last byte stalls
// in the input register only while a previous result is still waiting to be taken.
// local_mac is written through cfg_write/cfg_data, which the user must do only while the block
// is idle (the block does not enforce this); it gates which tcp frames are accepted.
module ethernet_header_classifier import ehc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [47:0] cfg_data,
  // byte stream in
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result out
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  packet_kind,
  output logic [2:0]  reject_reason,
  output logic [47:0] source_mac,
  output logic [47:0] target_mac,
  output logic [31:0] source_ip,
  output logic [31:0] target_ip,
  output logic [15:0] source_port,
  output logic [15:0] target_port
);

  // station mac
  logic [47:0] local_mac;

  // input register
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;

  // per-frame state
  logic [6:0]  byte_offset;
  logic [15:0] frame_type_word;
  logic [7:0]  ip_protocol;
  logic [3:0]  header_words;
  logic [47:0] held_source_mac;
  logic [47:0] held_target_mac;
  logic [31:0] held_source_ip;
  logic [31:0] held_target_ip;
  logic [15:0] held_source_port;
  logic [15:0] held_target_port;

  // captured values including the current byte
  logic [15:0] frame_type_word_next;
  logic [7:0]  ip_protocol_next;
  logic [3:0]  header_words_next;
  logic [47:0] held_source_mac_next;
  logic [47:0] held_target_mac_next;
  logic [31:0] held_source_ip_next;
  logic [31:0] held_target_ip_next;
  logic [15:0] held_source_port_next;
  logic [15:0] held_target_port_next;

  logic [6:0] port_base;
  logic [6:0] port_need;
  logic       port_proto;

  // classification of the frame ending at this beat
  logic [2:0] kind_next;
  logic [2:0] reason_next;
  logic       zero_all;
  logic       ports_on;

  logic process_fire;
  logic emit;

  // a byte moves on unless it closes a frame while the result register is still full
  assign process_fire = stage_valid && (!stage_last || !result_valid || result_ready);
  assign emit         = process_fire && stage_last;
  assign item_ready   = !stage_valid || process_fire;

  // ports start at 14 + 4*ihl; frame must reach 18 + 4*ihl bytes to hold both
  assign port_base  = OFS_PORT_BASE + {1'b0, header_words, 2'b00};
  assign port_need  = OFS_PORT_NEED + {1'b0, header_words_next, 2'b00};
  assign port_proto = (ip_protocol == PROTO_TCP) || (ip_protocol == PROTO_UDP);

  // field capture for the byte at byte_offset
  always_comb begin
    frame_type_word_next  = frame_type_word;
    ip_protocol_next      = ip_protocol;
    header_words_next     = header_words;
    held_source_mac_next  = held_source_mac;
    held_target_mac_next  = held_target_mac;
    held_source_ip_next   = held_source_ip;
    held_target_ip_next   = held_target_ip;
    held_source_port_next = held_source_port;
    held_target_port_next = held_target_port;

    if (byte_offset < OFS_SRC_MAC) begin
      held_target_mac_next = {held_target_mac[39:0], stage_byte};
    end else if (byte_offset < OFS_TYPE) begin
      held_source_mac_next = {held_source_mac[39:0], stage_byte};
    end else if (byte_offset < OFS_IHL) begin
      frame_type_word_next = {frame_type_word[7:0], stage_byte};
    end else if (frame_type_word == ETH_TYPE_IPV4) begin
      if (byte_offset == OFS_IHL) begin
        header_words_next = stage_byte[3:0] & IHL_MASK;
      end else if (byte_offset == OFS_PROTO) begin
        ip_protocol_next = stage_byte;
      end else if (byte_offset >= OFS_IP_SRC && byte_offset < OFS_IP_DST) begin
        held_source_ip_next = {held_source_ip[23:0], stage_byte};
      end else if (byte_offset >= OFS_IP_DST && byte_offset < OFS_IP_END) begin
        held_target_ip_next = {held_target_ip[23:0], stage_byte};
      end
      if (port_proto && header_words >= IHL_MIN && byte_offset >= OFS_IP_END) begin
        if (byte_offset == port_base || byte_offset == port_base + 7'd1) begin
          held_source_port_next = {held_source_port[7:0], stage_byte};
        end else if (byte_offset == port_base + 7'd2 || byte_offset == port_base + 7'd3) begin
          held_target_port_next = {held_target_port[7:0], stage_byte};
        end
      end
    end else if (frame_type_word == ETH_TYPE_ARP) begin
      if (byte_offset >= OFS_ARP_SMAC && byte_offset < OFS_ARP_SIP) begin
        held_source_mac_next = {held_source_mac[39:0], stage_byte};
      end else if (byte_offset >= OFS_ARP_SIP && byte_offset < OFS_ARP_TMAC) begin
        held_source_ip_next = {held_source_ip[23:0], stage_byte};
      end else if (byte_offset >= OFS_ARP_TMAC && byte_offset < OFS_ARP_TIP) begin
        held_target_mac_next = {held_target_mac[39:0], stage_byte};
      end else if (byte_offset >= OFS_ARP_TIP && byte_offset < OFS_ARP_END) begin
        held_target_ip_next = {held_target_ip[23:0], stage_byte};
      end
    end
  end

  // classification; frame length is byte_offset + 1, so "len < n" is "offset < n - 1"
  always_comb begin
    kind_next   = KIND_NONE;
    reason_next = RSN_OK;
    zero_all    = 1'b0;
    ports_on    = 1'b0;

    if (byte_offset < OFS_IHL - 7'd1) begin
      reason_next = RSN_TRUNC;
      zero_all    = 1'b1;
    end else if (frame_type_word_next == ETH_TYPE_IPV6) begin
      reason_next = RSN_IPV6;
    end else if (frame_type_word_next == ETH_TYPE_ARP) begin
      if (byte_offset < OFS_ARP_END - 7'd1) begin
        reason_next = RSN_TRUNC;
        zero_all    = 1'b1;
      end else begin
        kind_next = KIND_ARP;
      end
    end else if (frame_type_word_next == ETH_TYPE_IPV4) begin
      if (byte_offset < OFS_IP_END - 7'd1 || header_words_next < IHL_MIN) begin
        reason_next = RSN_TRUNC;
        zero_all    = 1'b1;
      end else if (ip_protocol_next == PROTO_IPV6) begin
        reason_next = RSN_IPV6;
      end else if (ip_protocol_next == PROTO_TCP || ip_protocol_next == PROTO_UDP) begin
        if (byte_offset < port_need) begin
          reason_next = RSN_TRUNC;
          zero_all    = 1'b1;
        end else if (ip_protocol_next == PROTO_TCP) begin
          if (held_source_mac_next != local_mac) begin
            reason_next = RSN_NOT_LOCAL;
          end else begin
            kind_next = KIND_TCP;
            ports_on  = 1'b1;
          end
        end else begin
          ports_on = 1'b1;
          if (held_target_port_next == DHCP_CLIENT_PORT &&
              held_source_port_next == DHCP_SERVER_PORT) begin
            kind_next = KIND_DHCP;
          end else begin
            kind_next = KIND_UDP;
          end
        end
      end else begin
        reason_next = RSN_PROTO;
      end
    end else begin
      reason_next = RSN_ETHERTYPE;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      local_mac <= '0;
    end else if (cfg_write) begin
      local_mac <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_byte <= data_byte;
      stage_last <= last_byte;
    end
  end

  // frame state: advance per byte, clear after the last beat
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      byte_offset      <= '0;
      frame_type_word  <= '0;
      ip_protocol      <= '0;
      header_words     <= '0;
      held_source_mac  <= '0;
      held_target_mac  <= '0;
      held_source_ip   <= '0;
      held_target_ip   <= '0;
      held_source_port <= '0;
      held_target_port <= '0;
    end else if (process_fire) begin
      if (byte_offset != OFS_MAX) begin
        byte_offset <= byte_offset + 7'd1;
      end
      frame_type_word  <= frame_type_word_next;
      ip_protocol      <= ip_protocol_next;
      header_words     <= header_words_next;
      held_source_mac  <= held_source_mac_next;
      held_target_mac  <= held_target_mac_next;
      held_source_ip   <= held_source_ip_next;
      held_target_ip   <= held_target_ip_next;
      held_source_port <= held_source_port_next;
      held_target_port <= held_target_port_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      packet_kind   <= kind_next;
      reject_reason <= reason_next;
      source_mac    <= zero_all ? '0 : held_source_mac_next;
      target_mac    <= zero_all ? '0 : held_target_mac_next;
      source_ip     <= zero_all ? '0 : held_source_ip_next;
      target_ip     <= zero_all ? '0 : held_target_ip_next;
      source_port   <= ports_on ? held_source_port_next : '0;
      target_port   <= ports_on ? held_target_port_next : '0;
    end
  end

endmodule

@@ verif/tb_ethernet_header_classifier.sv @@
`timescale 1ns / 1ps

module tb_ethernet_header_classifier;
  import ehc_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int REPORT_LIMIT = 40;

  // one classification result, field order follows the output ports
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  reason;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } frame_verdict_t;

  // frame recipes for the stimulus
  typedef enum {
    SHAPE_TCP_LOCAL, SHAPE_TCP_REMOTE, SHAPE_UDP, SHAPE_DHCP, SHAPE_ARP,
    SHAPE_IP_PROTO, SHAPE_IP_V6PROTO, SHAPE_IPV6, SHAPE_UNKNOWN, SHAPE_NOISE
  } frame_shape_t;

  // header parser model plus the queue of verdicts still owed by the block
  class frame_scoreboard_t;
    logic [47:0] local_mac;
    logic [6:0]  offset;
    logic [15:0] ethertype;
    logic [7:0]  protocol;
    logic [3:0]  ihl;
    logic [47:0] smac, tmac;
    logic [31:0] sip, tip;
    logic [15:0] sport, tport;
    frame_verdict_t owed_q[$];
    int errors;

    function new();
      local_mac = '0;
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      offset = '0;
      ethertype = '0;
      protocol = '0;
      ihl = '0;
      smac = '0;
      tmac = '0;
      sip = '0;
      tip = '0;
      sport = '0;
      tport = '0;
    endfunction

    // one accepted byte; a final byte queues the frame's verdict
    function void note_byte(logic [7:0] b, logic fin);
      int o;
      int len;
      int port_base;
      logic zero_all;
      logic keep_ports;
      frame_verdict_t v;
      o = int'(offset);
      if (o < 6) tmac = {tmac[39:0], b};
      else if (o < 12) smac = {smac[39:0], b};
      else if (o < 14) ethertype = {ethertype[7:0], b};
      else if (ethertype == ETH_TYPE_IPV4) begin
        if (o == OFS_IHL) ihl = b[3:0] & IHL_MASK;
        else if (o == OFS_PROTO) protocol = b;
        else if (o >= OFS_IP_SRC && o < OFS_IP_DST) sip = {sip[23:0], b};
        else if (o >= OFS_IP_DST && o < OFS_IP_END) tip = {tip[23:0], b};
        if ((protocol == PROTO_TCP || protocol == PROTO_UDP) && ihl >= IHL_MIN &&
            o >= OFS_IP_END) begin
          port_base = 14 + 4 * ihl;
          if (o >= port_base && o < port_base + 2) sport = {sport[7:0], b};
          else if (o >= port_base + 2 && o < port_base + 4) tport = {tport[7:0], b};
        end
      end else if (ethertype == ETH_TYPE_ARP) begin
        if (o >= OFS_ARP_SMAC && o < OFS_ARP_SIP) smac = {smac[39:0], b};
        else if (o >= OFS_ARP_SIP && o < OFS_ARP_TMAC) sip = {sip[23:0], b};
        else if (o >= OFS_ARP_TMAC && o < OFS_ARP_TIP) tmac = {tmac[39:0], b};
        else if (o >= OFS_ARP_TIP && o < OFS_ARP_END) tip = {tip[23:0], b};
      end
      if (offset != OFS_MAX) offset = offset + 7'd1;
      if (!fin) return;

      len = o + 1;
      v = '0;
      v.kind = KIND_NONE;
      v.reason = RSN_OK;
      zero_all = 1'b0;
      keep_ports = 1'b0;
      if (len < 14) begin
        v.reason = RSN_TRUNC;
        zero_all = 1'b1;
      end else if (ethertype == ETH_TYPE_IPV6) begin
        v.reason = RSN_IPV6;
      end else if (ethertype == ETH_TYPE_ARP) begin
        if (len < OFS_ARP_END) begin
          v.reason = RSN_TRUNC;
          zero_all = 1'b1;
        end else v.kind = KIND_ARP;
      end else if (ethertype == ETH_TYPE_IPV4) begin
        if (len < OFS_IP_END || ihl < IHL_MIN) begin
          v.reason = RSN_TRUNC;
          zero_all = 1'b1;
        end else if (protocol == PROTO_IPV6) begin
          v.reason = RSN_IPV6;
        end else if (protocol == PROTO_TCP || protocol == PROTO_UDP) begin
          if (len < 18 + 4 * ihl) begin
            v.reason = RSN_TRUNC;
            zero_all = 1'b1;
          end else if (protocol == PROTO_TCP) begin
            if (smac != local_mac) v.reason = RSN_NOT_LOCAL;
            else begin
              v.kind = KIND_TCP;
              keep_ports = 1'b1;
            end
          end else begin
            keep_ports = 1'b1;
            v.kind = (tport == DHCP_CLIENT_PORT && sport == DHCP_SERVER_PORT) ?
                     KIND_DHCP : KIND_UDP;
          end
        end else begin
          v.reason = RSN_PROTO;
        end
      end else begin
        v.reason = RSN_ETHERTYPE;
      end
      if (!zero_all) begin
        v.src_mac = smac;
        v.dst_mac = tmac;
        v.src_ip = sip;
        v.dst_ip = tip;
      end
      if (keep_ports) begin
        v.src_port = sport;
        v.dst_port = tport;
      end
      owed_q.push_back(v);
      clear_frame();
    endfunction

    function void compare_field(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // one accepted result beat against the oldest owed verdict
    function void check_result(frame_verdict_t got);
      frame_verdict_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = owed_q.pop_front();
      compare_field("packet_kind", 48'(want.kind), 48'(got.kind));
      compare_field("reject_reason", 48'(want.reason), 48'(got.reason));
      compare_field("source_mac", want.src_mac, got.src_mac);
      compare_field("target_mac", want.dst_mac, got.dst_mac);
      compare_field("source_ip", 48'(want.src_ip), 48'(got.src_ip));
      compare_field("target_ip", 48'(want.dst_ip), 48'(got.dst_ip));
      compare_field("source_port", 48'(want.src_port), 48'(got.src_port));
      compare_field("target_port", 48'(want.dst_port), 48'(got.dst_port));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [47:0] cfg_data;
  logic        item_valid;
  logic        item_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  packet_kind;
  logic [2:0]  reject_reason;
  logic [47:0] source_mac;
  logic [47:0] target_mac;
  logic [31:0] source_ip;
  logic [31:0] target_ip;
  logic [15:0] source_port;
  logic [15:0] target_port;

  frame_scoreboard_t sb;
  logic [7:0] frame_bytes[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int bytes_sent = 0;

  ethernet_header_classifier uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .packet_kind  (packet_kind),
    .reject_reason(reject_reason),
    .source_mac   (source_mac),
    .target_mac   (target_mac),
    .source_ip    (source_ip),
    .target_ip    (target_ip),
    .source_port  (source_port),
    .target_port  (target_port)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ethernet_header_classifier regression: fail");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off whenever the stimulus asks
  // for one so that the result register fills and the byte input backs up
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor: signals read right after the edge hold their pre-edge values
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_result({packet_kind, reject_reason, source_mac, target_mac,
                       source_ip, target_ip, source_port, target_port});
  end

  function automatic logic [47:0] random48();
    return {16'($urandom), $urandom};
  endfunction

  // append the low count bytes of v, most significant first
  task automatic push_bytes(input logic [47:0] v, input int count);
    for (int i = count - 1; i >= 0; i--) frame_bytes.push_back(v[8*i +: 8]);
  endtask

  // build one frame into frame_bytes; ihl only matters for ipv4 shapes,
  // pad adds random payload after the headers
  task automatic build_frame(input frame_shape_t shape, input int ihl, input int pad);
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] etype;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    frame_bytes.delete();
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(90, 1)) push_bytes(48'($urandom), 1);
      return;
    end
    // destination mac sometimes at the extremes
    case ($urandom_range(3))
      0: dst_mac = '0;
      1: dst_mac = '1;
      default: dst_mac = random48();
    endcase
    if (shape == SHAPE_TCP_LOCAL) src_mac = sb.local_mac;
    else begin
      src_mac = random48();
      if (src_mac == sb.local_mac) src_mac[0] = ~src_mac[0];
    end
    push_bytes(dst_mac, 6);
    push_bytes(src_mac, 6);

    case (shape)
      SHAPE_ARP: etype = ETH_TYPE_ARP;
      SHAPE_IPV6: etype = ETH_TYPE_IPV6;
      SHAPE_UNKNOWN: begin
        etype = 16'($urandom);
        while (etype == ETH_TYPE_IPV4 || etype == ETH_TYPE_ARP || etype == ETH_TYPE_IPV6)
          etype = 16'($urandom);
      end
      default: etype = ETH_TYPE_IPV4;
    endcase
    push_bytes(48'(etype), 2);

    if (etype == ETH_TYPE_IPV4) begin
      case (shape)
        SHAPE_TCP_LOCAL, SHAPE_TCP_REMOTE: proto = PROTO_TCP;
        SHAPE_UDP, SHAPE_DHCP: proto = PROTO_UDP;
        SHAPE_IP_V6PROTO: proto = PROTO_IPV6;
        default: begin
          proto = 8'($urandom);
          while (proto == PROTO_TCP || proto == PROTO_UDP || proto == PROTO_IPV6)
            proto = 8'($urandom);
        end
      endcase
      // udp ports: dhcp, near misses around the dhcp pair, or random
      sport = 16'($urandom);
      dport = 16'($urandom);
      if (shape == SHAPE_DHCP) begin
        sport = DHCP_SERVER_PORT;
        dport = DHCP_CLIENT_PORT;
      end else if (shape == SHAPE_UDP) begin
        case ($urandom_range(3))
          0: begin
            sport = DHCP_CLIENT_PORT;
            dport = DHCP_SERVER_PORT;
          end
          1: sport = DHCP_SERVER_PORT;
          2: dport = DHCP_CLIENT_PORT;
          default: ;
        endcase
      end
      push_bytes(48'({4'($urandom_range(15)), ihl[3:0]}), 1);
      repeat (8) push_bytes(48'($urandom), 1);
      push_bytes(48'(proto), 1);
      repeat (2) push_bytes(48'($urandom), 1);
      push_bytes(48'($urandom), 4);
      push_bytes(48'($urandom), 4);
      // ip options up to the transport header
      while (frame_bytes.size() < 14 + 4 * ihl) push_bytes(48'($urandom), 1);
      push_bytes(48'(sport), 2);
      push_bytes(48'(dport), 2);
    end else if (etype == ETH_TYPE_ARP) begin
      repeat (8) push_bytes(48'($urandom), 1);
      push_bytes(random48(), 6);
      push_bytes(48'($urandom), 4);
      push_bytes(random48(), 6);
      push_bytes(48'($urandom), 4);
    end
    repeat (pad) push_bytes(48'($urandom), 1);
  endtask

  // offer one beat, with random gaps before it, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  // build, optionally cut to keep bytes, and send one frame
  task automatic run_frame(input frame_shape_t shape, input int ihl, input int pad,
                           input int keep);
    build_frame(shape, ihl, pad);
    while (keep > 0 && frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // stop offering bytes until every owed verdict has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  // local_mac only changes with nothing in flight
  task automatic write_local_mac(input logic [47:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.local_mac = v;
  endtask

  initial begin
    int r;
    int ihl;
    int pad;
    int keep;
    int phase_start;
    int phase_frames;
    frame_shape_t shape;
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    item_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames: every kind, every reject, the truncation points,
    // ihl extremes and a frame running past the saturating offset
    write_local_mac(random48());
    run_frame(SHAPE_UNKNOWN, 5, 0, 1);     // single byte frame
    run_frame(SHAPE_UNKNOWN, 5, 0, 13);    // ends inside the ethertype
    run_frame(SHAPE_UNKNOWN, 5, 0, 0);     // bare 14-byte header
    run_frame(SHAPE_IPV6, 5, 8, 0);
    run_frame(SHAPE_ARP, 5, 0, 0);         // arp body exactly
    run_frame(SHAPE_ARP, 5, 0, 41);        // arp one byte short
    run_frame(SHAPE_ARP, 5, 18, 0);
    run_frame(SHAPE_TCP_LOCAL, 5, 0, 0);   // ports end on the last byte
    run_frame(SHAPE_TCP_LOCAL, 5, 0, 37);  // ports one byte short
    run_frame(SHAPE_TCP_LOCAL, 5, 0, 33);  // ip addresses one byte short
    run_frame(SHAPE_TCP_REMOTE, 5, 6, 0);
    run_frame(SHAPE_TCP_LOCAL, 15, 4, 0);  // largest header length
    run_frame(SHAPE_TCP_LOCAL, 4, 10, 0);  // header length too small
    run_frame(SHAPE_UDP, 0, 10, 0);
    run_frame(SHAPE_DHCP, 5, 8, 0);
    run_frame(SHAPE_UDP, 5, 8, 0);
    run_frame(SHAPE_UDP, 7, 2, 0);
    run_frame(SHAPE_IP_V6PROTO, 5, 4, 0);
    run_frame(SHAPE_IP_PROTO, 5, 4, 0);
    run_frame(SHAPE_DHCP, 5, 110, 0);      // long frame, offset saturates
    run_frame(SHAPE_NOISE, 5, 0, 0);

    // random phases, each with its own idling mix and local_mac setting
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          write_local_mac('0);
        end
        1: begin
          send_idle_pct = 66;
          recv_stall_pct <= 0;
          write_local_mac('1);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 66;
          write_local_mac(random48());
        end
        default: begin
          send_idle_pct = 30;
          recv_stall_pct <= 30;
          write_local_mac(random48());
        end
      endcase
      phase_start = bytes_sent;
      phase_frames = 0;
      while (bytes_sent - phase_start < 40 || phase_frames < 1) begin
        r = $urandom_range(99);
        if (r < 18) shape = SHAPE_TCP_LOCAL;
        else if (r < 26) shape = SHAPE_TCP_REMOTE;
        else if (r < 44) shape = SHAPE_UDP;
        else if (r < 54) shape = SHAPE_DHCP;
        else if (r < 68) shape = SHAPE_ARP;
        else if (r < 73) shape = SHAPE_IP_PROTO;
        else if (r < 76) shape = SHAPE_IP_V6PROTO;
        else if (r < 80) shape = SHAPE_IPV6;
        else if (r < 86) shape = SHAPE_UNKNOWN;
        else shape = SHAPE_NOISE;
        r = $urandom_range(99);
        if (r < 8) ihl = $urandom_range(4);
        else if (r < 60) ihl = 5;
        else ihl = $urandom_range(15, 5);
        pad = ($urandom_range(99) < 2) ? $urandom_range(200, 130) : $urandom_range(24);
        // a tenth of the frames end early at a random point
        keep = 0;
        if ($urandom_range(9) == 0) keep = $urandom_range(80, 1);
        run_frame(shape, ihl, pad, keep);
        phase_frames++;

        // back pressure: long result hold-off while short frames keep coming,
        // then a pause on the byte side until everything has drained
        if (phase == 0 && phase_frames == 1) begin
          hold_requests <= hold_requests + 1;
          repeat (4) run_frame(SHAPE_UNKNOWN, 5, 0, 0);
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("ethernet_header_classifier regression: pass");
    end else begin
      $display("ethernet_header_classifier regression: fail");
    end
    $finish;
  end

endmodule

@@ ethernet_header_classifier.f @@
sv/ehc_pkg.sv
sv/ethernet_header_classifier.sv
verif/tb_ethernet_header_classifier.sv
